// File: src/iplpm_pkg.sv
package iplpm_pkg;

  localparam int DEF_TABLE_DEPTH = 32;
  localparam int DEF_PORT_BITS   = 8;

  localparam int ADDR_BITS  = 32;
  localparam int LEN_BITS   = 6;
  localparam int INDEX_BITS = 5;
  localparam int OPORT_BITS = 8;

  localparam logic [ADDR_BITS-1:0] FULL_MASK  = 32'hFFFF_FFFF;
  localparam logic [LEN_BITS-1:0]  MAX_PREFIX = 6'd32;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Running best match of a lookup scan.
  typedef struct packed {
    logic                hit;
    logic [LEN_BITS-1:0] len;
  } best_t;

  // One table entry as the compare unit sees it.
  typedef struct packed {
    logic [ADDR_BITS-1:0] network;
    logic [LEN_BITS-1:0]  len;
  } entry_t;

endpackage

// File: src/iplpm_ram.sv
module iplpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/iplpm_match.sv
module iplpm_match (
  input  logic [iplpm_pkg::ADDR_BITS-1:0] dest,
  input  iplpm_pkg::entry_t               entry,
  input  iplpm_pkg::best_t                best,
  output logic                            take
);

  logic [iplpm_pkg::ADDR_BITS-1:0] mask;
  logic [iplpm_pkg::LEN_BITS-1:0]  shift;
  logic                            match;

  always_comb begin
    // Lengths are stored clamped to 32, so the shift stays in range.
    shift = iplpm_pkg::MAX_PREFIX - entry.len;
    if (entry.len == '0) begin
      mask = '0;
    end else begin
      mask = iplpm_pkg::FULL_MASK << shift;
    end
    match = (entry.len == '0) || ((dest & mask) == entry.network);
    // Strictly longer wins, so the lowest index keeps a tie.
    take = match && (!best.hit || (entry.len > best.len));
  end

endmodule

// File: src/ipv4_prefix_route_lookup_top.sv
// Write request: accepted while idle with no response; writes can follow back to back.
// Lookup request: with N = active_routes clamped to TABLE_DEPTH, the table RAM is read one
// entry per cycle and the single compare unit checks each entry in the cycle after its read;
// the result goes to the response register once all N entries are compared. The next request
// is accepted in the cycle after the response is loaded, and loading waits while an
// unaccepted response holds the result register.
// Reset (rst, synchronous): clears active_routes, the sequencer and the response
// valid; table contents are undefined until written.
module ipv4_prefix_route_lookup_top #(
  parameter int TABLE_DEPTH = iplpm_pkg::DEF_TABLE_DEPTH,
  parameter int PORT_BITS   = iplpm_pkg::DEF_PORT_BITS
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration channel: active_routes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data,
  // Request channel.
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata from bit 0: entry_index[4:0], entry_network[36:5],
  // entry_prefix_len[42:37], entry_port[50:43], dest_address[82:51], zero fill.
  input  logic [87:0] s_tdata,
  // s_tuser: command[0].
  input  logic [0:0]  s_tuser,
  // Response channel.
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata from bit 0: out_port[7:0], match_len[13:8], zero fill.
  output logic [15:0] m_tdata,
  // m_tuser: found[0].
  output logic [0:0]  m_tuser
);

  localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int WORD_W = iplpm_pkg::ADDR_BITS + iplpm_pkg::LEN_BITS + PORT_BITS;

  // Request fields.
  logic                              command;
  logic [iplpm_pkg::INDEX_BITS-1:0]  entry_index;
  logic [iplpm_pkg::ADDR_BITS-1:0]   entry_network;
  logic [iplpm_pkg::LEN_BITS-1:0]    entry_prefix_len;
  logic [iplpm_pkg::OPORT_BITS-1:0]  entry_port;
  logic [iplpm_pkg::ADDR_BITS-1:0]   dest_address;

  assign command          = s_tuser[0];
  assign entry_index      = s_tdata[4:0];
  assign entry_network    = s_tdata[36:5];
  assign entry_prefix_len = s_tdata[42:37];
  assign entry_port       = s_tdata[50:43];
  assign dest_address     = s_tdata[82:51];

  // Configuration register: user must write only while block is idle; not enforced.
  logic [iplpm_pkg::LEN_BITS-1:0] active_routes;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_routes <= '0;
    end else if (cfg_valid && cfg_ready) begin
      active_routes <= cfg_data;
    end
  end

  // Entry count of a lookup, clamped to the table depth.
  logic [15:0]      act_wide;
  logic [CNT_W-1:0] lookup_count;

  always_comb begin
    act_wide = 16'(active_routes);
    if (32'(active_routes) > 32'(TABLE_DEPTH)) begin
      lookup_count = CNT_W'(TABLE_DEPTH);
    end else begin
      lookup_count = act_wide[CNT_W-1:0];
    end
  end

  // Table write word: network, clamped length and port cut to PORT_BITS.
  logic [15:0]                    idx_wide;
  logic [15:0]                    port_wide;
  logic [iplpm_pkg::LEN_BITS-1:0] wr_len;
  logic [WORD_W-1:0]              wr_word;
  logic [AW-1:0]                  wr_addr;
  logic                           idx_ok;

  always_comb begin
    idx_wide  = 16'(entry_index);
    port_wide = 16'(entry_port);
    wr_addr   = idx_wide[AW-1:0];
    idx_ok    = 32'(entry_index) < 32'(TABLE_DEPTH);
    if (entry_prefix_len > iplpm_pkg::MAX_PREFIX) begin
      wr_len = iplpm_pkg::MAX_PREFIX;
    end else begin
      wr_len = entry_prefix_len;
    end
    wr_word = {entry_network, wr_len, port_wide[PORT_BITS-1:0]};
  end

  // Sequencer registers.
  iplpm_pkg::state_t state, state_next;
  logic [CNT_W-1:0]  issue_idx;
  logic [CNT_W-1:0]  count;
  logic              pend;
  logic [iplpm_pkg::ADDR_BITS-1:0] dest;
  iplpm_pkg::best_t  best;
  logic [PORT_BITS-1:0] best_port;

  logic ram_we;
  logic issuing;
  logic lookup_go;
  logic load_out;
  logic [WORD_W-1:0] rd_word;

  iplpm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (wr_word),
    .raddr (issue_idx[AW-1:0]),
    .rdata (rd_word)
  );

  // The single compare unit checks the entry read in the previous cycle.
  iplpm_pkg::entry_t    rd_entry;
  logic [PORT_BITS-1:0] rd_port;
  logic                 take;

  assign rd_entry.network = rd_word[WORD_W-1 -: iplpm_pkg::ADDR_BITS];
  assign rd_entry.len     = rd_word[PORT_BITS +: iplpm_pkg::LEN_BITS];
  assign rd_port          = rd_word[PORT_BITS-1:0];

  iplpm_match u_match (
    .dest  (dest),
    .entry (rd_entry),
    .best  (best),
    .take  (take)
  );

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    ram_we     = 1'b0;
    issuing    = 1'b0;
    lookup_go  = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      iplpm_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (command == iplpm_pkg::CMD_LOOKUP) begin
            lookup_go = 1'b1;
            if (lookup_count == '0) begin
              state_next = iplpm_pkg::ST_DONE;
            end else begin
              state_next = iplpm_pkg::ST_SCAN;
            end
          end else begin
            ram_we = idx_ok;
          end
        end
      end
      iplpm_pkg::ST_SCAN: begin
        issuing = issue_idx < count;
        // The last compare happens in the cycle after the last read is issued.
        if (!issuing && pend) begin
          state_next = iplpm_pkg::ST_DONE;
        end
      end
      iplpm_pkg::ST_DONE: begin
        // Hold the finished result until the response register is free.
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = iplpm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = iplpm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iplpm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      best <= '0;
    end else begin
      pend <= issuing;
      if (lookup_go) begin
        best <= '0;
      end else if (pend && take) begin
        best.hit <= 1'b1;
        best.len <= rd_entry.len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lookup_go) begin
      dest      <= dest_address;
      count     <= lookup_count;
      issue_idx <= '0;
      best_port <= '0;
    end else begin
      if (issuing) begin
        issue_idx <= issue_idx + 1'b1;
      end
      if (pend && take) begin
        best_port <= rd_port;
      end
    end
  end

  // Response register.
  logic [15:0] best_port_wide;

  assign best_port_wide = 16'(best_port);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tuser[0] <= best.hit;
      if (best.hit) begin
        m_tdata <= {2'b00, best.len, best_port_wide[7:0]};
      end else begin
        m_tdata <= '0;
      end
    end
  end

  // A miss carries a zero port and length.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
    else $error("miss response carries nonzero data");

  // A reported length never exceeds the address width.
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[13:8] <= iplpm_pkg::MAX_PREFIX))
    else $error("match length above 32");

  // The read pointer never runs past the clamped entry count.
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    (state == iplpm_pkg::ST_SCAN) |-> (issue_idx <= count))
    else $error("scan index beyond entry count");

  // A compare is only pending while scanning.
  a_pend_scan: assert property (@(posedge clk) disable iff (rst)
    pend |-> (state == iplpm_pkg::ST_SCAN))
    else $error("compare pending outside scan");

  // A lookup over a nonempty table starts a scan with a cleared best match.
  a_scan_start: assert property (@(posedge clk) disable iff (rst)
    (lookup_go && (lookup_count != '0)) |=>
      ((state == iplpm_pkg::ST_SCAN) && !best.hit && (issue_idx == '0)))
    else $error("lookup did not start a clean scan");

endmodule
